// ----- design/ssb_pkg.sv -----
// Shared types, constants and build-time tables for the SSB modulator.
// Holds the Hilbert tap ROM, the sine polynomial coefficients and the
// request/response structs passed between the datapath modules.
package ssb_pkg;

  localparam int HILBERT_TAPS = 31;
  localparam int LINE_LEN     = HILBERT_TAPS | 1;
  localparam int LINE_HALF    = LINE_LEN / 2;
  localparam int ADDR_W       = $clog2(LINE_LEN);
  localparam int ACC_W        = 32 + ADDR_W;
  localparam int MIX_W        = ACC_W + 17;

  localparam logic [30:0] SIN_A1 = 31'd1686629713;
  localparam logic [30:0] SIN_A3 = 31'd693598669;
  localparam logic [30:0] SIN_A5 = 31'd85569306;
  localparam logic [30:0] SIN_A7 = 31'd5026996;
  localparam logic [30:0] SIN_A9 = 31'd172272;

  localparam longint TWO_OVER_PI_Q30 = 683565276;
  localparam longint WIN_A0_Q30      = 450971566;
  localparam longint WIN_A1_Q15      = 16384;
  localparam longint WIN_A2_Q15      = 2621;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef logic signed [15:0]       sample_t;
  typedef logic signed [15:0]       tap_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [MIX_W-1:0]  mix_t;
  typedef tap_t                     tap_rom_t [LINE_LEN];

  localparam mix_t ROUND_HALF = mix_t'(64'sd1 <<< 29);

  typedef struct packed {
    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
    logic    rd_en;
    addr_t   rd_addr;
  } line_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] phase;
  } trig_req_t;

  typedef struct packed {
    logic    done;
    sample_t sin_v;
    sample_t cos_v;
  } trig_res_t;

  typedef struct packed {
    logic    start;
    acc_t    acc;
    sample_t i;
    sample_t sin_v;
    sample_t cos_v;
  } mix_req_t;

  typedef struct packed {
    logic    done;
    sample_t out_i;
    sample_t out_q;
  } mix_res_t;

  // Horner coefficient after the u^9 term, in evaluation order
  function automatic logic [30:0] sin_coef(input logic [1:0] idx);
    case (idx)
      2'd0:    return SIN_A7;
      2'd1:    return SIN_A5;
      2'd2:    return SIN_A3;
      default: return SIN_A1;
    endcase
  endfunction

  // Shift-subtract divide, build time only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sample_t sin_f(input logic [31:0] ph);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] s;
    u = 64'(ph[29:14]);
    if (ph[30]) u = 64'd65536 - u;
    u2 = u * u;
    p  = 64'(SIN_A9);
    p  = 64'(SIN_A7) - ((p * u2) >> 32);
    p  = 64'(SIN_A5) - ((p * u2) >> 32);
    p  = 64'(SIN_A3) - ((p * u2) >> 32);
    p  = 64'(SIN_A1) - ((p * u2) >> 32);
    r  = (p * u) >> 16;
    s  = (r + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return sample_t'(ph[31] ? (64'd0 - s) : s);
  endfunction

  function automatic tap_t tap_f(input int k);
    int          m;
    longint      am;
    longint      h;
    longint      w;
    longint      prod;
    longint      mag;
    longint      t;
    logic [31:0] ph;
    m = k - LINE_HALF;
    if (m[0] == 1'b0) return '0;
    am = (m < 0) ? -longint'(m) : longint'(m);
    h  = longint'(udiv(64'(TWO_OVER_PI_Q30 + (am >>> 1)), 64'(am)));
    ph = 32'(udiv({32'(k), 32'd0}, 64'(LINE_LEN - 1)));
    w  = WIN_A0_Q30
         - WIN_A1_Q15 * longint'(sin_f(ph + QUARTER_TURN))
         + WIN_A2_Q15 * longint'(sin_f({ph[30:0], 1'b0} + QUARTER_TURN));
    prod = h * w;
    mag  = (prod < 0) ? -prod : prod;
    t    = (mag + (longint'(1) <<< 44)) >>> 45;
    return ((prod < 0) != (m < 0)) ? tap_t'(-t) : tap_t'(t);
  endfunction

  function automatic tap_rom_t build_taps();
    tap_rom_t rom;
    for (int k = 0; k < LINE_LEN; k++) begin
      rom[k] = tap_f(k);
    end
    return rom;
  endfunction

  localparam tap_rom_t TAP_ROM = build_taps();

endpackage

// ----- design/ssb_line_mem.sv -----
// Circular sample delay line: one write port, one read port, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on ssb_pkg.
module ssb_line_mem import ssb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  line_req_t req,
  output sample_t   rd_data
);

  sample_t             mem_r [LINE_LEN];
  logic [LINE_LEN-1:0] valid_r;
  sample_t             rd_q_r;
  logic                rd_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (req.wr_en) valid_r[req.wr_addr] <= 1'b1;
      if (req.rd_en) rd_ok_r <= valid_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) mem_r[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_q_r <= mem_r[req.rd_addr];
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

// ----- design/ssb_trig.sv -----
// Sequential sine/cosine unit: quadrant fold plus a Horner polynomial on one
// shared multiplier, sine first and cosine second.
// Depends on ssb_pkg.
module ssb_trig import ssb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  trig_req_t req,
  output trig_res_t res
);

  typedef enum logic [2:0] {T_IDLE, T_U2, T_HORNER, T_ROUND, T_FIN} trig_state_t;

  trig_state_t state_r;
  logic [31:0] phase_r;
  logic        sel_r;
  logic [1:0]  quad_r;
  logic [16:0] u_r;
  logic [32:0] u2_r;
  logic [30:0] p_r;
  logic [1:0]  h_cnt_r;
  logic [30:0] rr_r;
  sample_t     sin_r;
  sample_t     cos_r;
  logic        done_r;

  logic [31:0] ang;
  logic [16:0] u_nxt;
  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [64:0] prod;
  logic [30:0] p_nxt;
  logic [16:0] s17;
  logic [14:0] mag;
  sample_t     val_nxt;

  assign ang   = sel_r ? (phase_r + QUARTER_TURN) : phase_r;
  assign u_nxt = ang[30] ? (17'd65536 - {1'b0, ang[29:14]}) : {1'b0, ang[29:14]};

  always_comb begin
    case (state_r)
      T_U2: begin
        mul_a = 32'(u_nxt);
        mul_b = 33'(u_nxt);
      end
      T_HORNER: begin
        mul_a = {1'b0, p_r};
        mul_b = u2_r;
      end
      T_ROUND: begin
        mul_a = {1'b0, p_r};
        mul_b = 33'(u_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = 65'(mul_a) * 65'(mul_b);
  assign p_nxt   = 31'(33'(sin_coef(h_cnt_r)) - prod[64:32]);
  assign s17     = 17'((32'(rr_r) + 32'd16384) >> 15);
  assign mag     = (s17 > 17'd32767) ? 15'h7fff : s17[14:0];
  assign val_nxt = quad_r[1] ? sample_t'(16'd0 - {1'b0, mag}) : sample_t'({1'b0, mag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        T_IDLE: begin
          if (req.start) begin
            phase_r <= req.phase;
            sel_r   <= 1'b0;
            done_r  <= 1'b0;
            state_r <= T_U2;
          end
        end
        T_U2: begin
          u_r     <= u_nxt;
          quad_r  <= ang[31:30];
          u2_r    <= prod[32:0];
          p_r     <= SIN_A9;
          h_cnt_r <= 2'd0;
          state_r <= T_HORNER;
        end
        T_HORNER: begin
          p_r     <= p_nxt;
          h_cnt_r <= h_cnt_r + 2'd1;
          if (h_cnt_r == 2'd3) state_r <= T_ROUND;
        end
        T_ROUND: begin
          rr_r    <= prod[46:16];
          state_r <= T_FIN;
        end
        T_FIN: begin
          if (!sel_r) begin
            sin_r   <= val_nxt;
            sel_r   <= 1'b1;
            state_r <= T_U2;
          end else begin
            cos_r   <= val_nxt;
            done_r  <= 1'b1;
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.sin_v = sin_r;
  assign res.cos_v = cos_r;

endmodule

// ----- design/ssb_mixer.sv -----
// Complex mixer: four products on one multiplier, then Q30 round half up
// and saturation to 16 bits. Depends on ssb_pkg.
module ssb_mixer import ssb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mix_req_t req,
  output mix_res_t res
);

  typedef enum logic [2:0] {
    M_IDLE, M_AS, M_IC, M_AC, M_IS, M_SUMQ, M_ROUND
  } mix_state_t;

  mix_state_t                 state_r;
  logic signed [ACC_W+15:0]   prod_r;
  mix_t                       re_r;
  mix_t                       im_r;
  sample_t                    out_i_r;
  sample_t                    out_q_r;
  logic                       done_r;

  acc_t                       mul_a;
  sample_t                    mul_b;
  logic signed [ACC_W+15:0]   prod;
  mix_t                       prod_ext;

  function automatic sample_t round_sat(input mix_t v);
    mix_t                      x;
    logic signed [MIX_W-31:0]  q;
    x = v + ROUND_HALF;
    q = x[MIX_W-1:30];
    if (q > (MIX_W-30)'(32767)) return sample_t'(16'h7fff);
    if (q < (MIX_W-30)'(-32768)) return sample_t'(16'h8000);
    return sample_t'(q);
  endfunction

  always_comb begin
    case (state_r)
      M_AS: begin
        mul_a = req.acc;
        mul_b = req.sin_v;
      end
      M_IC: begin
        mul_a = ACC_W'(req.i);
        mul_b = req.cos_v;
      end
      M_AC: begin
        mul_a = req.acc;
        mul_b = req.cos_v;
      end
      M_IS: begin
        mul_a = ACC_W'(req.i);
        mul_b = req.sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = MIX_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (req.start) state_r <= M_AS;
        end
        M_AS: begin
          prod_r  <= prod;
          state_r <= M_IC;
        end
        M_IC: begin
          re_r    <= -prod_ext;
          prod_r  <= prod;
          state_r <= M_AC;
        end
        M_AC: begin
          re_r    <= re_r + (prod_ext <<< 15);
          prod_r  <= prod;
          state_r <= M_IS;
        end
        M_IS: begin
          im_r    <= prod_ext;
          prod_r  <= prod;
          state_r <= M_SUMQ;
        end
        M_SUMQ: begin
          im_r    <= im_r + (prod_ext <<< 15);
          state_r <= M_ROUND;
        end
        M_ROUND: begin
          out_i_r <= round_sat(re_r);
          out_q_r <= round_sat(im_r);
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.out_i = out_i_r;
  assign res.out_q = out_q_r;

endmodule

// ----- design/ssb_usb_modulator.sv -----
// Top level of the upper-sideband SSB modulator: sequencer, FIR MAC and
// output register. Depends on ssb_pkg, ssb_line_mem, ssb_trig, ssb_mixer.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+-------------------------
//   input    | in_audio_sample                     | in_valid / in_ready
//   output   | out_i, out_q                        | out_valid / out_ready
//   config   | cfg_wdata (phase increment)         | cfg_we, no wait
//
// A request is accepted only in S_IDLE, and the next one only once it is done:
// the sweep of the 31-entry delay line through its single read port sets the
// pace, followed by the six-step mixer. Sine and cosine run alongside the sweep.
// A finished result sits in the output register, so a stalled out_ready only
// blocks the request after next. Reset (rst_n low, synchronous) clears the
// delay line, write position, carrier phase and phase increment at once.
module ssb_usb_modulator import ssb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  sample_t        in_audio_sample,
  output logic           out_valid,
  input  logic           out_ready,
  output sample_t        out_i,
  output sample_t        out_q
);

  typedef enum logic [2:0] {S_IDLE, S_FIR, S_DRAIN, S_WAIT, S_MIX, S_OUT} mod_state_t;

  mod_state_t  state_r;
  logic [31:0] inc_r;
  logic [31:0] phase_r;
  addr_t       pos_r;
  addr_t       addr_r;
  addr_t       k_r;
  logic        rd_vld_r;
  addr_t       rd_k_r;
  acc_t        acc_r;
  sample_t     i_r;
  logic        out_valid_r;
  sample_t     out_i_r;
  sample_t     out_q_r;

  logic                in_accept;
  logic                out_load;
  addr_t               pos_nxt;
  addr_t               addr_nxt;
  acc_t                acc_nxt;
  logic signed [31:0]  tap_prod;
  sample_t             rd_data;
  line_req_t           line_req;
  trig_req_t           trig_req;
  trig_res_t           trig_res;
  mix_req_t            mix_req;
  mix_res_t            mix_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign pos_nxt  = (pos_r == addr_t'(LINE_LEN - 1)) ? '0 : pos_r + 1'b1;
  assign addr_nxt = (addr_r == '0) ? addr_t'(LINE_LEN - 1) : addr_r - 1'b1;

  assign tap_prod = TAP_ROM[rd_k_r] * rd_data;
  assign acc_nxt  = acc_r + ACC_W'(tap_prod);

  assign line_req.wr_en   = in_accept;
  assign line_req.wr_addr = pos_r;
  assign line_req.wr_data = in_audio_sample;
  assign line_req.rd_en   = (state_r == S_FIR);
  assign line_req.rd_addr = addr_r;

  assign trig_req.start = in_accept;
  assign trig_req.phase = phase_r;

  assign mix_req.start = (state_r == S_WAIT) && trig_res.done;
  assign mix_req.acc   = acc_r;
  assign mix_req.i     = i_r;
  assign mix_req.sin_v = trig_res.sin_v;
  assign mix_req.cos_v = trig_res.cos_v;

  ssb_line_mem u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (line_req),
    .rd_data (rd_data)
  );

  ssb_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (trig_req),
    .res   (trig_res)
  );

  ssb_mixer u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mix_req),
    .res   (mix_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inc_r       <= '0;
      phase_r     <= '0;
      pos_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) inc_r <= cfg_wdata;

      rd_vld_r <= (state_r == S_FIR);
      rd_k_r   <= k_r;
      if (rd_vld_r) begin
        acc_r <= acc_nxt;
        if (rd_k_r == addr_t'(LINE_HALF)) i_r <= rd_data;
      end

      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            phase_r <= phase_r + inc_r;
            pos_r   <= pos_nxt;
            addr_r  <= pos_r;
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= S_FIR;
          end
        end
        S_FIR: begin
          addr_r <= addr_nxt;
          k_r    <= k_r + 1'b1;
          if (k_r == addr_t'(LINE_LEN - 1)) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= S_WAIT;
        S_WAIT: begin
          if (trig_res.done) state_r <= S_MIX;
        end
        S_MIX: begin
          if (mix_res.done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_i_r     <= mix_res.out_i;
            out_q_r     <= mix_res.out_q;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

endmodule
